/* rtl/core/pdfm_pkg.sv */
package pdfm_pkg;

    localparam logic [15:0] PERIOD_RESET = 16'd1000;
    localparam logic [14:0] DUTY_FULL    = 15'd25600;
    localparam logic [13:0] FREQ_SCALE   = 14'd16000;

    // controller to datapath
    typedef struct packed {
        logic load;       // take request into the counters and capture
        logic div_start;  // start a division
        logic div_sel;    // 0: frequency, 1: duty
        logic freq_store; // store the frequency quotient
        logic duty_store; // push duty into history
        logic sum_clear;  // clear average accumulator
        logic sum_step;   // add one history entry
        logic avg_start;  // start the averaging division
        logic avg_store;  // store the average
    } pdfm_cmd_t;

    // datapath to controller
    typedef struct packed {
        logic close;      // captured request closes a window
        logic div_busy;
        logic sum_last;   // the last valid entry is being added
    } pdfm_sts_t;

endpackage

/* rtl/core/pdfm_divider.sv */
module pdfm_divider #(
    parameter int NUM_BITS = 48,
    parameter int DEN_BITS = 32
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                start,
    input  logic [NUM_BITS-1:0] numer,
    input  logic [DEN_BITS-1:0] denom,
    output logic                busy,
    output logic [NUM_BITS-1:0] quot
);

    localparam int CNT_BITS = $clog2(NUM_BITS + 1);

    logic [NUM_BITS-1:0] quot_reg, quot_next;
    logic [DEN_BITS:0]   rem_reg, rem_next;
    logic [DEN_BITS-1:0] den_reg, den_next;
    logic [CNT_BITS-1:0] cnt_reg, cnt_next;
    logic                busy_reg, busy_next;
    logic [DEN_BITS:0]   trial;

    assign busy = busy_reg;
    assign quot = quot_reg;

    // one quotient bit per cycle, restoring
    always_comb
    begin
        quot_next = quot_reg;
        rem_next  = rem_reg;
        den_next  = den_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        trial     = {rem_reg[DEN_BITS-1:0], quot_reg[NUM_BITS-1]};
        if (start)
        begin
            quot_next = numer;
            rem_next  = '0;
            den_next  = denom;
            cnt_next  = CNT_BITS'(NUM_BITS);
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            if (trial >= {1'b0, den_reg})
            begin
                rem_next  = trial - {1'b0, den_reg};
                quot_next = {quot_reg[NUM_BITS-2:0], 1'b1};
            end
            else
            begin
                rem_next  = trial;
                quot_next = {quot_reg[NUM_BITS-2:0], 1'b0};
            end
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == CNT_BITS'(1))
            begin
                busy_next = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        quot_reg <= quot_next;
        rem_reg  <= rem_next;
        den_reg  <= den_next;
    end

endmodule

/* rtl/core/pdfm_datapath.sv */
module pdfm_datapath #(
    parameter int HISTORY_DEPTH = 8,
    parameter int COUNT_BITS    = 24
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               window_period_ms_we,
    input  logic [15:0]        window_period_ms,
    input  logic               pin_level,
    input  logic [31:0]        now_ms,
    input  pdfm_pkg::pdfm_cmd_t cmd,
    output pdfm_pkg::pdfm_sts_t sts,
    output logic [14:0]        duty_average,
    output logic [31:0]        frequency
);

    localparam int IDX_BITS  = (HISTORY_DEPTH > 1) ? $clog2(HISTORY_DEPTH) : 1;
    localparam int FILL_BITS = $clog2(HISTORY_DEPTH + 1);
    localparam int SUM_BITS  = 15 + FILL_BITS;
    localparam int NUM_BITS  = (COUNT_BITS + 15 > 33) ? COUNT_BITS + 15 : 33;
    localparam logic [COUNT_BITS-1:0] COUNT_MAX = '1;

    logic [15:0]           period_reg;
    logic [COUNT_BITS-1:0] high_reg, total_reg, edge_reg;
    logic [COUNT_BITS-1:0] high_next, total_next, edge_next;
    logic                  prev_reg;
    logic [31:0]           start_reg;
    logic [31:0]           elapsed;
    logic [31:0]           elapsed_reg;
    logic                  level_reg;
    logic                  close_reg;
    logic [14:0]           hist_mem [HISTORY_DEPTH];
    logic [HISTORY_DEPTH-1:0] hist_valid_reg;
    logic [IDX_BITS-1:0]   idx_reg, rd_reg;
    logic [FILL_BITS-1:0]  fill_reg, cnt_reg;
    logic [SUM_BITS-1:0]   sum_reg;
    logic [14:0]           duty_reg;
    logic [31:0]           freq_reg;
    logic [14:0]           rd_data;
    logic [14:0]           win_duty;
    logic                  div_busy;
    logic [NUM_BITS-1:0]   div_quot, div_num;
    logic [31:0]           div_den;

    assign duty_average = duty_reg;
    assign frequency    = freq_reg;

    // count this poll
    always_comb
    begin
        high_next  = high_reg;
        total_next = (total_reg == COUNT_MAX) ? total_reg : total_reg + 1'b1;
        edge_next  = edge_reg;
        if (pin_level && high_reg != COUNT_MAX)
        begin
            high_next = high_reg + 1'b1;
        end
        if (!prev_reg && pin_level && edge_reg != COUNT_MAX)
        begin
            edge_next = edge_reg + 1'b1;
        end
        elapsed = now_ms - start_reg;
    end

    assign sts.close    = close_reg;
    assign sts.div_busy = div_busy;
    assign sts.sum_last = (cnt_reg == fill_reg - 1'b1);

    // divider operands
    always_comb
    begin
        if (!cmd.div_sel)
        begin
            div_num = NUM_BITS'({edge_reg, 14'd0}) - NUM_BITS'({edge_reg, 8'd0})
                      - NUM_BITS'({edge_reg, 7'd0});
            div_den = (elapsed_reg == '0) ? 32'd1 : elapsed_reg;
        end
        else
        begin
            div_num = NUM_BITS'({high_reg, 14'd0}) + NUM_BITS'({high_reg, 13'd0})
                      + NUM_BITS'({high_reg, 10'd0});
            div_den = 32'(total_reg);
        end
        if (cmd.avg_start)
        begin
            div_num = NUM_BITS'(sum_reg);
            div_den = 32'(fill_reg);
        end
    end

    assign win_duty = (edge_reg == '0) ? (level_reg ? pdfm_pkg::DUTY_FULL : 15'd0)
                                       : div_quot[14:0];
    assign rd_data  = hist_valid_reg[rd_reg] ? hist_mem[rd_reg] : 15'd0;

    pdfm_divider #(.NUM_BITS(NUM_BITS), .DEN_BITS(32)) u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (cmd.div_start | cmd.avg_start),
        .numer (div_num),
        .denom (div_den),
        .busy  (div_busy),
        .quot  (div_quot)
    );

    // hold control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            period_reg     <= pdfm_pkg::PERIOD_RESET;
            high_reg       <= '0;
            total_reg      <= '0;
            edge_reg       <= '0;
            prev_reg       <= 1'b0;
            start_reg      <= '0;
            close_reg      <= 1'b0;
            hist_valid_reg <= '0;
            idx_reg        <= '0;
            fill_reg       <= '0;
            cnt_reg        <= '0;
            rd_reg         <= '0;
            duty_reg       <= '0;
            freq_reg       <= '0;
        end
        else
        begin
            if (window_period_ms_we)
            begin
                period_reg <= window_period_ms;
            end
            if (cmd.load)
            begin
                prev_reg <= pin_level;
                close_reg <= (elapsed >= 32'(period_reg));
                high_reg  <= high_next;
                total_reg <= total_next;
                edge_reg  <= edge_next;
                if (elapsed >= 32'(period_reg))
                begin
                    start_reg <= now_ms;
                end
            end
            if (cmd.freq_store)
            begin
                freq_reg <= (div_quot[NUM_BITS-1:32] != '0) ? 32'hFFFF_FFFF
                                                            : div_quot[31:0];
            end
            if (cmd.duty_store)
            begin
                hist_valid_reg[idx_reg] <= 1'b1;
                idx_reg <= (idx_reg == IDX_BITS'(HISTORY_DEPTH - 1)) ? '0
                                                                     : idx_reg + 1'b1;
                if (fill_reg != FILL_BITS'(HISTORY_DEPTH))
                begin
                    fill_reg <= fill_reg + 1'b1;
                end
                high_reg  <= '0;
                total_reg <= '0;
                edge_reg  <= '0;
            end
            if (cmd.sum_clear)
            begin
                cnt_reg <= '0;
                rd_reg  <= '0;
            end
            else if (cmd.sum_step)
            begin
                cnt_reg <= cnt_reg + 1'b1;
                rd_reg  <= rd_reg + 1'b1;
            end
            if (cmd.avg_store)
            begin
                duty_reg <= div_quot[14:0];
            end
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            elapsed_reg <= elapsed;
            level_reg   <= pin_level;
        end
        if (cmd.duty_store)
        begin
            hist_mem[idx_reg] <= win_duty;
        end
        if (cmd.sum_clear)
        begin
            sum_reg <= '0;
        end
        else if (cmd.sum_step)
        begin
            sum_reg <= sum_reg + SUM_BITS'(rd_data);
        end
    end

`ifndef SYNTH
    a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
        fill_reg <= FILL_BITS'(HISTORY_DEPTH))
        else $error("history fill overrun");
    a_total_ge_high: assert property (@(posedge clk) disable iff (!rst_n)
        total_reg >= high_reg)
        else $error("high count above total");
    a_start_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.div_start || cmd.avg_start) |-> !div_busy)
        else $error("divider started while busy");
`endif

endmodule

/* rtl/core/pdfm_ctrl.sv */
module pdfm_ctrl (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    output logic                out_valid,
    input  logic                out_ready,
    output logic                window_done,
    output pdfm_pkg::pdfm_cmd_t cmd,
    input  pdfm_pkg::pdfm_sts_t sts
);

    typedef enum logic [3:0] {
        S_IDLE, S_CHECK, S_FREQ, S_FWAIT, S_DUTY, S_DWAIT, S_SUM, S_AVG, S_AWAIT
    } state_t;

    state_t state_reg, state_next;
    logic   out_valid_reg, out_valid_next;
    logic   done_reg, done_next;

    assign in_ready    = (state_reg == S_IDLE) && (!out_valid_reg || out_ready);
    assign out_valid   = out_valid_reg;
    assign window_done = done_reg;

    // sequence each poll and the window close
    always_comb
    begin
        state_next     = state_reg;
        out_valid_next = out_valid_reg && !out_ready;
        done_next      = done_reg;
        cmd            = '0;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid && in_ready)
                begin
                    cmd.load   = 1'b1;
                    state_next = S_CHECK;
                end
            end
            S_CHECK:
            begin
                if (sts.close)
                begin
                    state_next = S_FREQ;
                end
                else
                begin
                    out_valid_next = 1'b1;
                    done_next      = 1'b0;
                    state_next     = S_IDLE;
                end
            end
            S_FREQ:
            begin
                cmd.div_start = 1'b1;
                state_next    = S_FWAIT;
            end
            S_FWAIT:
            begin
                if (!sts.div_busy)
                begin
                    cmd.freq_store = 1'b1;
                    state_next     = S_DUTY;
                end
            end
            S_DUTY:
            begin
                cmd.div_sel   = 1'b1;
                cmd.div_start = 1'b1;
                state_next    = S_DWAIT;
            end
            S_DWAIT:
            begin
                cmd.div_sel = 1'b1;
                if (!sts.div_busy)
                begin
                    cmd.duty_store = 1'b1;
                    cmd.sum_clear  = 1'b1;
                    state_next     = S_SUM;
                end
            end
            S_SUM:
            begin
                cmd.sum_step = 1'b1;
                if (sts.sum_last)
                begin
                    state_next = S_AVG;
                end
            end
            S_AVG:
            begin
                cmd.avg_start = 1'b1;
                state_next    = S_AWAIT;
            end
            S_AWAIT:
            begin
                if (!sts.div_busy)
                begin
                    cmd.avg_store  = 1'b1;
                    out_valid_next = 1'b1;
                    done_next      = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
            done_reg      <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
            done_reg      <= done_next;
        end
    end

`ifndef SYNTH
    a_ready_idle: assert property (@(posedge clk) disable iff (!rst_n)
        in_ready |-> state_reg == S_IDLE)
        else $error("ready outside idle");
    a_one_out: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_CHECK && !sts.close) |=> out_valid)
        else $error("missing result");
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !out_ready) |=> (out_valid && $stable(window_done)))
        else $error("result dropped or changed while waiting");
`endif

endmodule

/* rtl/core/pwm_duty_frequency_meter_core.sv */
// Channel | Direction | Signals
// cfg     | in        | window_period_ms_we, window_period_ms
// poll    | in        | in_valid, in_ready, pin_level, now_ms
// result  | out       | out_valid, out_ready, duty_average, frequency, window_done
// An ordinary poll is captured, then window-tested; the next poll can
// enter in the same cycle that the previous result is taken.
// A window-closing poll then runs the shared one-bit-per-cycle divider three
// times: frequency, duty, and the average over the history entries.
// Reset clears counters, history valid bits and held results; no clearing pass.
module pwm_duty_frequency_meter_core #(
    parameter int HISTORY_DEPTH = 8,
    parameter int COUNT_BITS    = 24
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        window_period_ms_we,
    input  logic [15:0] window_period_ms,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic        pin_level,
    input  logic [31:0] now_ms,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [14:0] duty_average,
    output logic [31:0] frequency,
    output logic        window_done
);

    pdfm_pkg::pdfm_cmd_t cmd;
    pdfm_pkg::pdfm_sts_t sts;

    pdfm_ctrl u_ctrl (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .window_done (window_done),
        .cmd         (cmd),
        .sts         (sts)
    );

    pdfm_datapath #(.HISTORY_DEPTH(HISTORY_DEPTH), .COUNT_BITS(COUNT_BITS)) u_dp (
        .clk                 (clk),
        .rst_n               (rst_n),
        .window_period_ms_we (window_period_ms_we),
        .window_period_ms    (window_period_ms),
        .pin_level           (pin_level),
        .now_ms              (now_ms),
        .cmd                 (cmd),
        .sts                 (sts),
        .duty_average        (duty_average),
        .frequency           (frequency)
    );

endmodule
